@@ hdl/ddesc_pkg.sv @@
`default_nettype none

package ddesc_pkg;

    localparam int SPEED_FRAC_BITS = 12;

    // Mixed speeds live in units of 2^-(2F+1); magnitudes stay below 2^32.
    localparam int SUM_W   = 34;
    localparam int MAG_W   = 32;
    localparam int NUM_W   = 46;
    localparam int DEN_W   = MAG_W + 1;
    localparam int QUO_W   = 17;
    localparam int DSH_W   = DEN_W + QUO_W - 1;
    localparam int STEP_W  = 5;
    localparam int PULSE_W = 13;
    localparam int OFF_W   = 12;
    localparam int PROD_W  = MAG_W + 16;

    localparam logic [STEP_W-1:0] PULSE_STEPS = STEP_W'(OFF_W);
    localparam logic [STEP_W-1:0] DUTY_STEPS  = STEP_W'(QUO_W);

    localparam logic [MAG_W-1:0] ONE_MIX = MAG_W'(64'd1 << (2 * SPEED_FRAC_BITS + 1));
    localparam logic [MAG_W-1:0] ONE_DIR = MAG_W'(64'd1 << SPEED_FRAC_BITS);

    localparam logic [11:0] NEUTRAL_RST = 12'd1520;
    localparam logic [10:0] DELTA_RST   = 11'd480;
    localparam logic [15:0] PERIOD_RST  = 16'd20000;
    localparam logic [15:0] TRACK_RST   = 16'd4096;
    localparam logic [15:0] LIMIT_RST   = 16'd2000;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_MIX    = 2'd1,
        OP_DIRECT = 2'd2,
        OP_STOP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_NEUTRAL    = 3'd0,
        CFG_DELTA      = 3'd1,
        CFG_PERIOD     = 3'd2,
        CFG_TRACK      = 3'd3,
        CFG_WDOG_LIMIT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        op_t                operation;
        logic signed [15:0] forward_speed;
        logic signed [15:0] turn_rate;
        logic signed [15:0] left_command;
        logic signed [15:0] right_command;
    } in_item_t;

    typedef struct packed {
        logic [PULSE_W-1:0] left_pulse_us;
        logic [PULSE_W-1:0] right_pulse_us;
        logic [15:0]        left_duty;
        logic [15:0]        right_duty;
        logic               watchdog_fired;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ hdl/ddesc_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle, most significant first.
module ddesc_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ddesc_pkg::div_req_t req,
    output ddesc_pkg::div_rsp_t      rsp
);
    import ddesc_pkg::*;

    logic [NUM_W-1:0]  rem_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              fits;

    assign fits = DSH_W'(rem_reg) >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num;
            dsh_reg <= DSH_W'(req.den) << (req.steps - 1'b1);
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg[NUM_W-1:0];
            end
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

@@ hdl/differential_drive_esc_pulse_mixer.sv @@
`default_nettype none

// Differential-drive mixer with servo pulse and duty outputs. One item is taken
// at a time and gives one result; none is taken before the last one reaches the
// output register. Tick and stop items run only the duty divisions, direct
// speed items add the pulse divisions and mix items the mixing too. One shared
// restoring divider produces one quotient bit per cycle: 12 bits for each pulse
// offset, 17 bits for each duty value, run once per motor side. A shared 32x16
// multiplier forms the turn product and the offset numerators. The next item is
// taken while a finished result still waits on the output. Configuration writes
// apply at once; held pulses stay; duty always uses the current frame period.
module differential_drive_esc_pulse_mixer (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire ddesc_pkg::in_item_t  in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output ddesc_pkg::out_item_t      out_item,
    input  wire logic                 cfg_write,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [15:0]          cfg_data
);
    import ddesc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX_MUL,
        S_MIX_SUM,
        S_MIX_DEN,
        S_PULSE_MUL,
        S_PULSE_DIV,
        S_PULSE_WAIT,
        S_DUTY_DIV,
        S_DUTY_WAIT,
        S_DONE
    } state_t;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [SUM_W-1:0] x);
        logic [SUM_W-1:0] a;
        a = x[SUM_W-1] ? SUM_W'(-x) : SUM_W'(x);
        return a[MAG_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] clamp_one(input logic signed [15:0] s);
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] one;
        x   = SUM_W'(s);
        one = $signed(SUM_W'(ONE_DIR));
        if (x > one)
            return one;
        else if (x < -one)
            return -one;
        else
            return x;
    endfunction

    state_t                  state_reg;
    logic                    side_reg;
    in_item_t                item_reg;

    logic [11:0]             neutral_reg;
    logic [10:0]             delta_reg;
    logic [15:0]             period_reg;
    logic [15:0]             track_reg;
    logic [15:0]             limit_reg;

    logic [PULSE_W-1:0]      left_pulse_reg;
    logic [PULSE_W-1:0]      right_pulse_reg;
    logic [15:0]             idle_ticks_reg;
    logic                    armed_reg;
    logic                    fired_reg;

    logic signed [SUM_W-1:0] vl_reg;
    logic signed [SUM_W-1:0] vr_reg;
    logic [MAG_W-1:0]        den_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [15:0]             left_duty_reg;
    logic [15:0]             right_duty_reg;

    logic                    out_valid_reg;
    out_item_t               out_item_reg;

    logic [MAG_W-1:0]        mul_a;
    logic [15:0]             mul_b;
    logic [PROD_W-1:0]       prod_next;
    logic signed [SUM_W-1:0] cur_v;
    logic [PULSE_W-1:0]      cur_pulse;
    logic [OFF_W-1:0]        off;
    logic [PULSE_W-1:0]      pulse_next;
    logic [15:0]             duty_next;
    logic [15:0]             tick_inc;
    logic signed [SUM_W-1:0] v_ext;
    logic signed [SUM_W-1:0] turn_s;
    logic [MAG_W-1:0]        mag_l;
    logic [MAG_W-1:0]        mag_r;
    logic [MAG_W-1:0]        mag_max;
    logic                    accept;

    div_req_t                div_req;
    div_rsp_t                div_rsp;

    ddesc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign cur_v     = side_reg ? vr_reg : vl_reg;
    assign cur_pulse = side_reg ? right_pulse_reg : left_pulse_reg;
    assign tick_inc  = idle_ticks_reg + 16'd1;

    assign v_ext  = SUM_W'(item_reg.forward_speed) <<< (SPEED_FRAC_BITS + 1);
    assign turn_s = item_reg.turn_rate[15] ? -$signed(SUM_W'(prod_reg[MAG_W-1:0]))
                                           :  $signed(SUM_W'(prod_reg[MAG_W-1:0]));
    assign mag_l   = mag_of(vl_reg);
    assign mag_r   = mag_of(vr_reg);
    assign mag_max = (mag_l > mag_r) ? mag_l : mag_r;

    // Shared multiplier operands.
    always_comb
    begin
        if (state_reg == S_MIX_MUL)
        begin
            mul_a = MAG_W'(mag_of(SUM_W'(item_reg.turn_rate)));
            mul_b = track_reg;
        end
        else
        begin
            mul_a = mag_of(cur_v);
            mul_b = 16'(delta_reg);
        end
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Shared divider requests.
    always_comb
    begin
        div_req = '0;
        case (state_reg)
            S_PULSE_DIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'({prod_reg, 1'b0}) + NUM_W'(den_reg);
                div_req.den   = {den_reg, 1'b0};
                div_req.steps = PULSE_STEPS;
            end
            S_DUTY_DIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'({cur_pulse, 16'b0}) - NUM_W'(cur_pulse);
                div_req.den   = DEN_W'(period_reg);
                div_req.steps = DUTY_STEPS;
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    // Round-half-away offset applied around neutral, floored at zero.
    always_comb
    begin
        off = div_rsp.quo[OFF_W-1:0];
        if (cur_v[SUM_W-1])
            pulse_next = (PULSE_W'(off) > PULSE_W'(neutral_reg)) ? '0
                       : PULSE_W'(neutral_reg) - PULSE_W'(off);
        else
            pulse_next = PULSE_W'(neutral_reg) + PULSE_W'(off);
    end

    // Quotient at or above 2^16 (or a zero period) saturates.
    assign duty_next = div_rsp.quo[QUO_W-1] ? 16'hFFFF : div_rsp.quo[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            side_reg        <= 1'b0;
            neutral_reg     <= NEUTRAL_RST;
            delta_reg       <= DELTA_RST;
            period_reg      <= PERIOD_RST;
            track_reg       <= TRACK_RST;
            limit_reg       <= LIMIT_RST;
            left_pulse_reg  <= PULSE_W'(NEUTRAL_RST);
            right_pulse_reg <= PULSE_W'(NEUTRAL_RST);
            idle_ticks_reg  <= '0;
            armed_reg       <= 1'b1;
            fired_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_NEUTRAL:    neutral_reg <= cfg_data[11:0];
                    CFG_DELTA:      delta_reg   <= cfg_data[10:0];
                    CFG_PERIOD:     period_reg  <= cfg_data;
                    CFG_TRACK:      track_reg   <= cfg_data;
                    CFG_WDOG_LIMIT: limit_reg   <= cfg_data;
                    default:        ;
                endcase
            end

            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    side_reg <= 1'b0;
                    if (accept)
                    begin
                        fired_reg <= (in_item.operation == OP_TICK) && armed_reg
                                  && (tick_inc >= limit_reg);
                        case (in_item.operation)
                            OP_TICK:
                            begin
                                state_reg <= S_DUTY_DIV;
                                if (armed_reg)
                                begin
                                    if (tick_inc >= limit_reg)
                                    begin
                                        left_pulse_reg  <= PULSE_W'(neutral_reg);
                                        right_pulse_reg <= PULSE_W'(neutral_reg);
                                        armed_reg       <= 1'b0;
                                        idle_ticks_reg  <= '0;
                                    end
                                    else
                                    begin
                                        idle_ticks_reg <= tick_inc;
                                    end
                                end
                            end
                            OP_MIX:
                            begin
                                state_reg      <= S_MIX_MUL;
                                idle_ticks_reg <= '0;
                                armed_reg      <= 1'b1;
                            end
                            OP_DIRECT:
                            begin
                                state_reg      <= S_PULSE_MUL;
                                idle_ticks_reg <= '0;
                                armed_reg      <= 1'b1;
                            end
                            default:
                            begin
                                state_reg       <= S_DUTY_DIV;
                                left_pulse_reg  <= PULSE_W'(neutral_reg);
                                right_pulse_reg <= PULSE_W'(neutral_reg);
                            end
                        endcase
                    end
                end
                S_MIX_MUL:   state_reg <= S_MIX_SUM;
                S_MIX_SUM:   state_reg <= S_MIX_DEN;
                S_MIX_DEN:   state_reg <= S_PULSE_MUL;
                S_PULSE_MUL: state_reg <= S_PULSE_DIV;
                S_PULSE_DIV: state_reg <= S_PULSE_WAIT;
                S_PULSE_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        if (side_reg)
                        begin
                            right_pulse_reg <= pulse_next;
                            side_reg        <= 1'b0;
                            state_reg       <= S_DUTY_DIV;
                        end
                        else
                        begin
                            left_pulse_reg <= pulse_next;
                            side_reg       <= 1'b1;
                            state_reg      <= S_PULSE_MUL;
                        end
                    end
                end
                S_DUTY_DIV:  state_reg <= S_DUTY_WAIT;
                S_DUTY_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        side_reg  <= ~side_reg;
                        state_reg <= side_reg ? S_DONE : S_DUTY_DIV;
                    end
                end
                S_DONE:
                begin
                    // Hold until the output register is free.
                    if (!out_valid_reg || out_ready)
                        state_reg <= S_IDLE;
                end
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
            vl_reg   <= clamp_one(in_item.left_command);
            vr_reg   <= clamp_one(in_item.right_command);
            den_reg  <= ONE_DIR;
        end
        if (state_reg == S_MIX_MUL || state_reg == S_PULSE_MUL)
            prod_reg <= prod_next;
        if (state_reg == S_MIX_SUM)
        begin
            vl_reg <= v_ext - turn_s;
            vr_reg <= v_ext + turn_s;
        end
        if (state_reg == S_MIX_DEN)
            den_reg <= (mag_max > ONE_MIX) ? mag_max : ONE_MIX;
        if (state_reg == S_DUTY_WAIT && div_rsp.done)
        begin
            if (side_reg)
                right_duty_reg <= duty_next;
            else
                left_duty_reg <= duty_next;
        end
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            out_item_reg.left_pulse_us  <= left_pulse_reg;
            out_item_reg.right_pulse_us <= right_pulse_reg;
            out_item_reg.left_duty      <= left_duty_reg;
            out_item_reg.right_duty     <= right_duty_reg;
            out_item_reg.watchdog_fired <= fired_reg;
        end
    end

endmodule

`default_nettype wire
